### hdl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg
// Types, character codes and event codes shared by the S-record loader.
// ----------------------------------------------------------------------------
`default_nettype none

package srl_pkg;

	typedef enum logic [3:0] {
		PH_WAIT      = 4'd0,
		PH_ABORT_CR  = 4'd1,
		PH_TYPE      = 4'd2,
		PH_SKIP_LINE = 4'd3,
		PH_END_EOL   = 4'd4,
		PH_COUNT     = 4'd5,
		PH_ADDRESS   = 4'd6,
		PH_DATA      = 4'd7,
		PH_CHECKSUM  = 4'd8,
		PH_TRAILER   = 4'd9,
		PH_FINISHED  = 4'd10
	} phase_t;

	localparam logic [2:0] EV_DATA     = 3'd0;
	localparam logic [2:0] EV_FILL     = 3'd1;
	localparam logic [2:0] EV_DONE     = 3'd2;
	localparam logic [2:0] EV_ABORT    = 3'd3;
	localparam logic [2:0] EV_ADDR_ERR = 3'd4;

	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_S_UP   = 8'h53;
	localparam logic [7:0] CH_S_LO   = 8'h73;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_1      = 8'h31;
	localparam logic [7:0] CH_2      = 8'h32;
	localparam logic [7:0] CH_3      = 8'h33;
	localparam logic [7:0] CH_7      = 8'h37;
	localparam logic [7:0] CH_8      = 8'h38;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] FILL_BYTE = 8'hFF;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [31:0] offset;
		logic [7:0]  byte_value;
		logic [31:0] run_length;
		logic        bad_type;
	} result_t;

	// Anything that is not a hex digit reads as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [3:0] n;
		n = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
		else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h37);
		else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h57);
		return n;
	endfunction

endpackage

`default_nettype wire

### hdl/srl_parser.sv
// ----------------------------------------------------------------------------
// srl_parser
// Record state machine: consumes one character per step, updates the parse
// registers and produces at most one result for that character.
// ----------------------------------------------------------------------------
`default_nettype none

module srl_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [31:0]       cfg_wr_data,
	input  wire logic              step_en,
	input  wire logic [7:0]        step_char,
	output logic                   res_valid,
	output srl_pkg::result_t       res
);

	srl_pkg::phase_t phase_q, phase_d;
	logic [2:0]  abc_q, abc_d;
	logic [3:0]  hdc_q, hdc_d;
	logic [31:0] asm_q, asm_d;
	logic [31:0] next_addr_q, next_addr_d;
	logic [7:0]  left_q, left_d;
	logic [31:0] img_len_q, img_len_d;
	logic        bad_q, bad_d;

	logic [31:0] asm_shift;
	logic [3:0]  hdc_inc;
	logic [3:0]  digits;
	logic        field_done;
	logic [7:0]  v8;
	logic [7:0]  abc_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= srl_pkg::PH_WAIT;
			abc_q       <= 3'd0;
			hdc_q       <= 4'd0;
			asm_q       <= 32'd0;
			next_addr_q <= 32'd0;
			left_q      <= 8'd0;
			img_len_q   <= 32'd0;
			bad_q       <= 1'b0;
		end else if (cfg_wr_en) begin
			// A base write restarts the load from the new base.
			phase_q     <= srl_pkg::PH_WAIT;
			abc_q       <= 3'd0;
			hdc_q       <= 4'd0;
			asm_q       <= 32'd0;
			next_addr_q <= cfg_wr_data;
			left_q      <= 8'd0;
			img_len_q   <= 32'd0;
			bad_q       <= 1'b0;
		end else if (step_en) begin
			phase_q     <= phase_d;
			abc_q       <= abc_d;
			hdc_q       <= hdc_d;
			asm_q       <= asm_d;
			next_addr_q <= next_addr_d;
			left_q      <= left_d;
			img_len_q   <= img_len_d;
			bad_q       <= bad_d;
		end
	end

	assign asm_shift  = {asm_q[27:0], srl_pkg::hex_nibble(step_char)};
	assign hdc_inc    = hdc_q + 4'd1;
	assign digits     = (phase_q == srl_pkg::PH_ADDRESS) ? {abc_q, 1'b0} : 4'd2;
	assign field_done = (hdc_inc >= digits);
	assign v8         = asm_shift[7:0];
	assign abc_p1     = {5'd0, abc_q} + 8'd1;

	always_comb begin
		phase_d     = phase_q;
		abc_d       = abc_q;
		hdc_d       = hdc_q;
		asm_d       = asm_q;
		next_addr_d = next_addr_q;
		left_d      = left_q;
		img_len_d   = img_len_q;
		bad_d       = bad_q;
		res_valid   = 1'b0;
		res         = '0;

		case (phase_q)
			srl_pkg::PH_WAIT: begin
				if (step_char == srl_pkg::CH_DOT) begin
					phase_d = srl_pkg::PH_ABORT_CR;
				end else if (step_char == srl_pkg::CH_S_UP || step_char == srl_pkg::CH_S_LO) begin
					phase_d = srl_pkg::PH_TYPE;
				end
			end
			srl_pkg::PH_ABORT_CR: begin
				if (step_char == srl_pkg::CH_CR) begin
					phase_d       = srl_pkg::PH_FINISHED;
					res_valid     = 1'b1;
					res.event_res = srl_pkg::EV_ABORT;
				end
			end
			srl_pkg::PH_TYPE: begin
				hdc_d = 4'd0;
				asm_d = 32'd0;
				if (step_char == srl_pkg::CH_0) begin
					phase_d = srl_pkg::PH_SKIP_LINE;
				end else if (step_char == srl_pkg::CH_1) begin
					abc_d   = 3'd2;
					phase_d = srl_pkg::PH_COUNT;
				end else if (step_char == srl_pkg::CH_2) begin
					abc_d   = 3'd3;
					phase_d = srl_pkg::PH_COUNT;
				end else if (step_char == srl_pkg::CH_3) begin
					abc_d   = 3'd4;
					phase_d = srl_pkg::PH_COUNT;
				end else if (step_char == srl_pkg::CH_7 || step_char == srl_pkg::CH_8
						|| step_char == srl_pkg::CH_9) begin
					bad_d   = 1'b0;
					phase_d = srl_pkg::PH_END_EOL;
				end else begin
					bad_d   = 1'b1;
					phase_d = srl_pkg::PH_END_EOL;
				end
			end
			srl_pkg::PH_SKIP_LINE: begin
				if (step_char == srl_pkg::CH_CR || step_char == srl_pkg::CH_LF) begin
					phase_d = srl_pkg::PH_WAIT;
				end
			end
			srl_pkg::PH_END_EOL: begin
				if (step_char == srl_pkg::CH_CR || step_char == srl_pkg::CH_LF) begin
					phase_d        = srl_pkg::PH_FINISHED;
					res_valid      = 1'b1;
					res.event_res  = srl_pkg::EV_DONE;
					res.run_length = img_len_q;
					res.bad_type   = bad_q;
				end
			end
			srl_pkg::PH_COUNT: begin
				asm_d = asm_shift;
				hdc_d = field_done ? 4'd0 : hdc_inc;
				if (field_done) begin
					// Data byte count is the record count less address and checksum.
					left_d  = (v8 > abc_p1) ? (v8 - abc_p1) : 8'd0;
					asm_d   = 32'd0;
					phase_d = srl_pkg::PH_ADDRESS;
				end
			end
			srl_pkg::PH_ADDRESS: begin
				asm_d = asm_shift;
				hdc_d = field_done ? 4'd0 : hdc_inc;
				if (field_done) begin
					asm_d   = 32'd0;
					phase_d = (left_q != 8'd0) ? srl_pkg::PH_DATA : srl_pkg::PH_CHECKSUM;
					if (asm_shift < next_addr_q) begin
						phase_d       = srl_pkg::PH_FINISHED;
						res_valid     = 1'b1;
						res.event_res = srl_pkg::EV_ADDR_ERR;
						res.offset    = img_len_q;
					end else if (asm_shift != next_addr_q) begin
						res_valid      = 1'b1;
						res.event_res  = srl_pkg::EV_FILL;
						res.offset     = img_len_q;
						res.byte_value = srl_pkg::FILL_BYTE;
						res.run_length = asm_shift - next_addr_q;
						img_len_d      = img_len_q + (asm_shift - next_addr_q);
						next_addr_d    = asm_shift;
					end
				end
			end
			srl_pkg::PH_DATA: begin
				asm_d = asm_shift;
				hdc_d = field_done ? 4'd0 : hdc_inc;
				if (field_done) begin
					asm_d          = 32'd0;
					img_len_d      = img_len_q + 32'd1;
					next_addr_d    = next_addr_q + 32'd1;
					left_d         = left_q - 8'd1;
					if (left_q == 8'd1) phase_d = srl_pkg::PH_CHECKSUM;
					res_valid      = 1'b1;
					res.event_res  = srl_pkg::EV_DATA;
					res.offset     = img_len_q;
					res.byte_value = v8;
				end
			end
			srl_pkg::PH_CHECKSUM: begin
				asm_d = asm_shift;
				hdc_d = field_done ? 4'd0 : hdc_inc;
				if (field_done) begin
					asm_d   = 32'd0;
					phase_d = srl_pkg::PH_TRAILER;
				end
			end
			srl_pkg::PH_TRAILER: begin
				phase_d = srl_pkg::PH_WAIT;
			end
			default: begin
				phase_d = srl_pkg::PH_FINISHED;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/srecord_stream_loader_unit.sv
// A character accepted into the input register steps the parser, and
// its result (if any) goes to the output register: two register stages.
// Throughput: one character per cycle while the output register is free or
// draining; record state updates in a single parser step, which sets the rate.
// Reset: arst_n clears all parse state, the base address reads as zero,
// and both the input and the output register come up empty.
// ----------------------------------------------------------------------------
// srecord_stream_loader_unit
// Motorola S-record character stream to image write requests.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_stream_loader_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,   // [31:0] offset, [39:32] byte_value,
	                                         // [71:40] run_length
	output logic [3:0]       m_axis_tuser    // [2:0] event_res, [3] bad_type
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                advance;
	logic                res_valid;
	srl_pkg::result_t    res;
	logic                out_valid_q;
	srl_pkg::result_t    out_q;

	// The parser steps when the input register holds a character and the output register is free or being drained.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
		end
	end

	srl_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (advance),
		.step_char   (char_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.run_length, out_q.byte_value, out_q.offset};
	assign m_axis_tuser  = {out_q.bad_type, out_q.event_res};

	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[2:0] <= srl_pkg::EV_ADDR_ERR))
		else $error("event code out of range");

	a_fill_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:0] == srl_pkg::EV_FILL)
		|-> (m_axis_tdata[71:40] != 32'd0 && m_axis_tdata[39:32] == srl_pkg::FILL_BYTE))
		else $error("fill request with empty run or wrong fill byte");

	a_bad_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:0] != srl_pkg::EV_DONE) |-> !m_axis_tuser[3])
		else $error("bad type flag outside a done request");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(char_s1)))
		else $error("input register lost a character while stalled");

endmodule

`default_nettype wire
